// ===== hw/rtl/jqc_pkg.sv =====
package jqc_pkg;

    localparam int SUM_W  = 24;
    localparam int E_W    = 16;
    localparam int PCT_W  = 7;
    localparam int ETA_W  = 11;
    localparam int PT_W   = 16;
    localparam int TYPE_W = 3;
    localparam int Q_W    = 3;
    localparam int CNT_W  = 2;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 16;
    localparam int PROD_W = SUM_W + PCT_W;

    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [PCT_W-1:0] HUNDRED   = 7'd100;

    // particle types
    localparam logic [TYPE_W-1:0] PT_OTHER    = 3'd0;
    localparam logic [TYPE_W-1:0] PT_CHARGED  = 3'd1;
    localparam logic [TYPE_W-1:0] PT_PHOTON   = 3'd2;
    localparam logic [TYPE_W-1:0] PT_NEUTRAL  = 3'd3;
    localparam logic [TYPE_W-1:0] PT_ELECTRON = 3'd4;
    localparam logic [TYPE_W-1:0] PT_HF_HAD   = 3'd5;
    localparam logic [TYPE_W-1:0] PT_HF_EGAM  = 3'd6;

    // quality codes
    localparam logic [Q_W-1:0] Q_FAIL   = 3'd0;
    localparam logic [Q_W-1:0] Q_LOOSE  = 3'd1;
    localparam logic [Q_W-1:0] Q_MEDIUM = 3'd2;
    localparam logic [Q_W-1:0] Q_TIGHT  = 3'd3;
    localparam logic [Q_W-1:0] Q_LOW_PT = 3'd4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_LOOSE   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_MEDIUM  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TIGHT   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_ETA     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_MIN_PT  = 3'd4;

    localparam logic [PCT_W-1:0] LOOSE_RST  = 7'd99;
    localparam logic [PCT_W-1:0] MEDIUM_RST = 7'd95;
    localparam logic [PCT_W-1:0] TIGHT_RST  = 7'd90;
    localparam logic [ETA_W-1:0] ETA_RST    = 11'd614;
    localparam logic [PT_W-1:0]  MIN_PT_RST = 16'd40;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] charged;
        logic [SUM_W-1:0] photon;
        logic [SUM_W-1:0] neutral;
        logic [SUM_W-1:0] electron;
        logic [CNT_W-1:0] count;
        logic             has_charged;
        logic             central;
        logic             low_pt;
    } jqc_summary_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [E_W-1:0] e);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + {{(SUM_W+1-E_W){1'b0}}, e};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/jet_quality_classifier.sv =====
// The jet summary formed with the last constituent is held in the jet summary register,
// then its code in the result register. One constituent per cycle while item_stall is low;
// the input, jet summary and result registers each advance whenever the next stage has room.
// Reset (rst_n low, asynchronous): configuration returns to its defaults, all sums
// and counts clear, and every pipeline stage empties.
module jet_quality_classifier
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [jqc_pkg::TYPE_W-1:0]  particle_type,
    input  logic [jqc_pkg::E_W-1:0]     energy,
    input  logic [jqc_pkg::PT_W-1:0]    jet_pt,
    input  logic [jqc_pkg::ETA_W-1:0]   jet_abs_eta,
    input  logic                        last,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [jqc_pkg::Q_W-1:0]     quality,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [jqc_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [jqc_pkg::CDAT_W-1:0]  cfg_data
);

    // configuration
    logic [jqc_pkg::PCT_W-1:0] loose_reg, medium_reg, tight_reg;
    logic [jqc_pkg::ETA_W-1:0] eta_bound_reg;
    logic [jqc_pkg::PT_W-1:0]  min_pt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loose_reg     <= jqc_pkg::LOOSE_RST;
            medium_reg    <= jqc_pkg::MEDIUM_RST;
            tight_reg     <= jqc_pkg::TIGHT_RST;
            eta_bound_reg <= jqc_pkg::ETA_RST;
            min_pt_reg    <= jqc_pkg::MIN_PT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jqc_pkg::REG_LOOSE:  loose_reg     <= cfg_data[jqc_pkg::PCT_W-1:0];
                jqc_pkg::REG_MEDIUM: medium_reg    <= cfg_data[jqc_pkg::PCT_W-1:0];
                jqc_pkg::REG_TIGHT:  tight_reg     <= cfg_data[jqc_pkg::PCT_W-1:0];
                jqc_pkg::REG_ETA:    eta_bound_reg <= cfg_data[jqc_pkg::ETA_W-1:0];
                jqc_pkg::REG_MIN_PT: min_pt_reg    <= cfg_data[jqc_pkg::PT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake
    logic s0_valid_reg, s1_valid_reg, out_valid_reg;
    logic s0_last_reg;
    logic out_ready, s1_ready, s0_fire, s0_ready;

    assign out_ready  = !out_valid_reg || !result_stall;
    assign s1_ready   = !s1_valid_reg || out_ready;
    assign s0_fire    = s0_valid_reg && (!s0_last_reg || s1_ready);
    assign s0_ready   = !s0_valid_reg || s0_fire;
    assign item_stall = !s0_ready;

    // input register
    logic [jqc_pkg::TYPE_W-1:0] s0_type_reg;
    logic [jqc_pkg::E_W-1:0]    s0_energy_reg;
    logic [jqc_pkg::PT_W-1:0]   s0_pt_reg;
    logic [jqc_pkg::ETA_W-1:0]  s0_eta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s0_ready)
            s0_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && item_valid)
        begin
            s0_type_reg   <= particle_type;
            s0_energy_reg <= energy;
            s0_pt_reg     <= jet_pt;
            s0_eta_reg    <= jet_abs_eta;
            s0_last_reg   <= last;
        end
    end

    // accumulators
    logic [jqc_pkg::SUM_W-1:0] tot_reg, chg_reg, pho_reg, neu_reg, ele_reg;
    logic [jqc_pkg::CNT_W-1:0] cnt_reg;
    logic                      hasc_reg;
    jqc_pkg::jqc_summary_t     acc_next;

    always_comb
    begin
        acc_next             = '0;
        acc_next.total       = jqc_pkg::sat_add(tot_reg, s0_energy_reg);
        acc_next.charged     = chg_reg;
        acc_next.photon      = pho_reg;
        acc_next.neutral     = neu_reg;
        acc_next.electron    = ele_reg;
        acc_next.count       = (cnt_reg == jqc_pkg::COUNT_MAX) ? cnt_reg
                                                               : cnt_reg + 1'b1;
        acc_next.has_charged = hasc_reg;
        acc_next.central     = (s0_eta_reg <= eta_bound_reg);
        acc_next.low_pt      = (s0_pt_reg < min_pt_reg);
        case (s0_type_reg)
            jqc_pkg::PT_CHARGED:
            begin
                acc_next.charged     = jqc_pkg::sat_add(chg_reg, s0_energy_reg);
                acc_next.has_charged = 1'b1;
            end
            jqc_pkg::PT_PHOTON, jqc_pkg::PT_HF_EGAM:
                acc_next.photon = jqc_pkg::sat_add(pho_reg, s0_energy_reg);
            jqc_pkg::PT_NEUTRAL:
                acc_next.neutral = jqc_pkg::sat_add(neu_reg, s0_energy_reg);
            jqc_pkg::PT_ELECTRON:
                acc_next.electron = jqc_pkg::sat_add(ele_reg, s0_energy_reg);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_reg  <= '0;
            chg_reg  <= '0;
            pho_reg  <= '0;
            neu_reg  <= '0;
            ele_reg  <= '0;
            cnt_reg  <= '0;
            hasc_reg <= 1'b0;
        end
        else if (s0_fire)
        begin
            if (s0_last_reg)
            begin
                // jet closes: start the next one from zero
                tot_reg  <= '0;
                chg_reg  <= '0;
                pho_reg  <= '0;
                neu_reg  <= '0;
                ele_reg  <= '0;
                cnt_reg  <= '0;
                hasc_reg <= 1'b0;
            end
            else
            begin
                tot_reg  <= acc_next.total;
                chg_reg  <= acc_next.charged;
                pho_reg  <= acc_next.photon;
                neu_reg  <= acc_next.neutral;
                ele_reg  <= acc_next.electron;
                cnt_reg  <= acc_next.count;
                hasc_reg <= acc_next.has_charged;
            end
        end
    end

    // jet summary register
    jqc_pkg::jqc_summary_t s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= s0_fire && s0_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s0_fire && s0_last_reg)
            s1_reg <= acc_next;
    end

    // classification: part/total < pct/100 as part*100 < pct*total
    logic [jqc_pkg::PROD_W-1:0] neu_x100, pho_x100, ele_x100;
    logic [jqc_pkg::PROD_W-1:0] tot_loose, tot_medium, tot_tight;
    logic                       tot_nz, multi, chg_ok;
    logic                       n_l, p_l, e_l, n_m, p_m, n_t, p_t;
    logic                       n_c, p_c, e_c;
    logic                       lvl_l, lvl_m, lvl_t;
    logic [jqc_pkg::Q_W-1:0]    code;

    always_comb
    begin
        neu_x100   = {{(jqc_pkg::PROD_W-jqc_pkg::SUM_W){1'b0}}, s1_reg.neutral}
                     * {{(jqc_pkg::PROD_W-jqc_pkg::PCT_W){1'b0}}, jqc_pkg::HUNDRED};
        pho_x100   = {{(jqc_pkg::PROD_W-jqc_pkg::SUM_W){1'b0}}, s1_reg.photon}
                     * {{(jqc_pkg::PROD_W-jqc_pkg::PCT_W){1'b0}}, jqc_pkg::HUNDRED};
        ele_x100   = {{(jqc_pkg::PROD_W-jqc_pkg::SUM_W){1'b0}}, s1_reg.electron}
                     * {{(jqc_pkg::PROD_W-jqc_pkg::PCT_W){1'b0}}, jqc_pkg::HUNDRED};
        tot_loose  = {{(jqc_pkg::PROD_W-jqc_pkg::SUM_W){1'b0}}, s1_reg.total}
                     * {{(jqc_pkg::PROD_W-jqc_pkg::PCT_W){1'b0}}, loose_reg};
        tot_medium = {{(jqc_pkg::PROD_W-jqc_pkg::SUM_W){1'b0}}, s1_reg.total}
                     * {{(jqc_pkg::PROD_W-jqc_pkg::PCT_W){1'b0}}, medium_reg};
        tot_tight  = {{(jqc_pkg::PROD_W-jqc_pkg::SUM_W){1'b0}}, s1_reg.total}
                     * {{(jqc_pkg::PROD_W-jqc_pkg::PCT_W){1'b0}}, tight_reg};
        tot_nz     = (s1_reg.total != '0);
        multi      = (s1_reg.count > 2'd1);
        chg_ok     = (s1_reg.charged != '0) && s1_reg.has_charged;

        n_l = tot_nz && (neu_x100 < tot_loose);
        p_l = tot_nz && (pho_x100 < tot_loose);
        e_l = tot_nz && (ele_x100 < tot_loose);
        n_m = tot_nz && (neu_x100 < tot_medium);
        p_m = tot_nz && (pho_x100 < tot_medium);
        n_t = tot_nz && (neu_x100 < tot_tight);
        p_t = tot_nz && (pho_x100 < tot_tight);
        // a 100 percent limit reduces to part < total
        n_c = tot_nz && (s1_reg.neutral  < s1_reg.total);
        p_c = tot_nz && (s1_reg.photon   < s1_reg.total);
        e_c = tot_nz && (s1_reg.electron < s1_reg.total);

        if (s1_reg.central)
        begin
            lvl_l = n_l && p_l && multi && chg_ok && e_l;
            lvl_m = n_c && p_c && multi && chg_ok && e_c;
            lvl_t = lvl_m;
        end
        else
        begin
            lvl_l = n_l && p_l && multi;
            lvl_m = n_m && p_m && multi;
            lvl_t = n_t && p_t && multi;
        end

        if (s1_reg.low_pt)
            code = jqc_pkg::Q_LOW_PT;
        else if (lvl_l && !lvl_m && !lvl_t)
            code = jqc_pkg::Q_LOOSE;
        else if (lvl_l && lvl_m && !lvl_t)
            code = jqc_pkg::Q_MEDIUM;
        else if (lvl_l && lvl_m && lvl_t)
            code = jqc_pkg::Q_TIGHT;
        else
            code = jqc_pkg::Q_FAIL;
    end

    // result register
    logic [jqc_pkg::Q_W-1:0] quality_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
            quality_reg <= code;
    end

    assign result_valid = out_valid_reg;
    assign quality      = quality_reg;

endmodule

// ===== hw/rtl/jqc_checker.sv =====
module jqc_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic                        item_stall,
    input  logic                        last,
    input  logic                        result_valid,
    input  logic                        result_stall,
    input  logic [jqc_pkg::Q_W-1:0]     quality,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready
);

    // hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(quality))
        else $error("stalled result changed");

    a_quality_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> quality <= jqc_pkg::Q_LOW_PT)
        else $error("quality code out of range");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration request refused");

    // with nothing in flight and the output free, a non-last request never yields a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && !item_stall && !(item_valid && last) &&
        $past(!item_valid, 1) && $past(!item_valid, 2) && $past(!result_valid, 1)
        |=> !result_valid)
        else $error("result without a last constituent");

endmodule

bind jet_quality_classifier jqc_checker u_jqc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .quality      (quality),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
